### rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg: shared types, constants and helpers for the rotation matrix block
// Holds pipeline depths and widths, CORDIC constants and the stage payload record.
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int CORDIC_STAGES = 24;
   localparam int SQRT_STEPS    = 32;       // one result bit per step
   localparam int DIV_BITS      = 31;       // quotient bits, at most 2^30
   localparam int DIV_STEPS     = DIV_BITS;

   localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
   localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
   localparam logic signed [31:0] D2R_Q32   = 32'sd74961321;
   localparam logic signed [25:0] DEG_180   = 26'sd11796480;
   localparam logic signed [25:0] DEG_360   = 26'sd23592960;
   localparam logic signed [25:0] DEG_90    = 26'sd5898240;

   function automatic logic [31:0] atan_q30(input int i);
      logic [31:0] t [0:31];
      t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
            32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
            32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
            32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
            32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
            32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
            32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000};
      return t[i & 31];
   endfunction

   // round to nearest, ties away from zero, drop 30 bits, clamp to +-1
   function automatic logic signed [31:0] rnd_sat(input logic signed [67:0] v);
      logic [67:0] m;
      logic [67:0] q;
      logic signed [68:0] s;
      m = v[67] ? 68'(-v) : 68'(v);
      q = (m + 68'd536870912) >> 30;
      s = v[67] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (s > 69'sd1073741824)       return 32'sd1073741824;
      else if (s < -69'sd1073741824) return -32'sd1073741824;
      else                           return s[31:0];
   endfunction

   // per-item record carried alongside the pipeline to the matrix stages
   typedef struct packed {
      logic        zero;
      logic [2:0]  neg;      // axis signs
      logic        negc;
      logic signed [33:0] z; // angle, Q2.30 radians
   } side_type;

endpackage

### rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix: Rodrigues rotation matrix from axis and angle
// Normalises the axis, reduces the angle, runs a CORDIC and forms R.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req_    | in  | tdata: axis_x, axis_y, axis_z, angle_deg
//  rsp_    | out | tdata: r00..r22; tuser: zero_axis
//
//  One beat enters per cycle unless rsp_ stalls. The pipe is 3 + 32 + 31
//  normaliser stages, 2 matrix stages, output register (CORDIC alongside).
//  The depth is set by the square root and divider, one bit per stage.
//  Reset (synchronous) clears all valid bits; payload is not reset.
//  A stall on rsp_ freezes the whole pipe; the output register holds.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix import aarm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // axis_x[31:0], axis_y[63:32], axis_z[95:64], angle_deg[121:96], zero fill
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // r00[31:0], r01, r02, r10, r11, r12, r20, r21, r22[287:256]
   output logic [287:0] rsp_tdata,
   // zero_axis[0]
   output logic         rsp_tuser
);

   localparam int NLAT = 3 + SQRT_STEPS + DIV_STEPS;
   localparam int CLAT = CORDIC_STAGES;

   logic en;
   logic fin_valid;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // input decode, angle reduction
   logic signed [31:0] ax [0:2];
   logic [31:0]        am [0:2];
   logic signed [25:0] d0, d1;
   logic               negc;
   logic signed [57:0] zp;
   logic signed [33:0] zr;
   side_type           side_in;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ax[k] = req_tdata[32*k +: 32];
         am[k] = ax[k][31] ? 32'(-ax[k]) : 32'(ax[k]);
      end
      d0 = req_tdata[121:96];
      if (d0 > DEG_180)       d0 = d0 - DEG_360;
      else if (d0 < -DEG_180) d0 = d0 + DEG_360;
      negc = 1'b0;
      d1 = d0;
      if (d0 > DEG_90)       begin d1 = DEG_180 - d0;  negc = 1'b1; end
      else if (d0 < -DEG_90) begin d1 = -DEG_180 - d0; negc = 1'b1; end
      zp = 58'(d1) * 58'(D2R_Q32);
      begin
         logic [57:0] mg;
         logic [57:0] q;
         mg = zp[57] ? 58'(-zp) : 58'(zp);
         q  = (mg + 58'd131072) >> 18;
         zr = zp[57] ? -$signed(34'(q)) : $signed(34'(q));
      end
      side_in.zero = (am[0] | am[1] | am[2]) == '0;
      side_in.neg  = {ax[2][31], ax[1][31], ax[0][31]};
      side_in.negc = negc;
      side_in.z    = zr;
   end

   logic acc;
   assign acc = req_tvalid && req_tready;

   // normaliser
   logic        n_valid;
   logic [30:0] uq [0:2];
   aarm_norm u_norm (
      .clock(clock), .reset(reset), .en(en), .in_valid(acc), .in_m(am),
      .out_valid(n_valid), .out_q(uq)
   );

   // side delay to line the CORDIC output and flags up with the normaliser
   side_type sd_ff [0:NLAT-CLAT];
   assign sd_ff[0] = side_in;
   for (genvar i = 0; i < NLAT - CLAT; i++) begin : g_sd
      always_ff @(posedge clock) begin
         if (en) sd_ff[i+1] <= sd_ff[i];
      end
   end

   // CORDIC output lines up with n_valid, which qualifies it
   logic signed [33:0] cx, cy;
   aarm_cordic u_cordic (
      .clock(clock), .en(en),
      .in_z(sd_ff[NLAT-CLAT].z),
      .out_x(cx), .out_y(cy)
   );

   side_type sc_ff [0:CLAT];
   assign sc_ff[0] = sd_ff[NLAT-CLAT];
   for (genvar i = 0; i < CLAT; i++) begin : g_sc
      always_ff @(posedge clock) begin
         if (en) sc_ff[i+1] <= sc_ff[i];
      end
   end

   // stage M1: signed axis, cos/sin/t, pair products
   logic               v1_ff;
   side_type           s1_ff;
   logic signed [31:0] a1_ff [0:2];
   logic signed [33:0] c1_ff, sn1_ff, t1_ff;
   logic signed [31:0] p1_ff [0:5]; // xx yy zz xy xz yz
   logic signed [31:0] au [0:2];
   logic signed [33:0] cc;
   always_comb begin
      for (int k = 0; k < 3; k++)
         au[k] = sc_ff[CLAT].neg[k] ? -$signed({1'b0, uq[k]}) : $signed({1'b0, uq[k]});
      cc = sc_ff[CLAT].negc ? -cx : cx;
      if (cc > ONE_Q30) cc = ONE_Q30;
      else if (cc < -ONE_Q30) cc = -ONE_Q30;
   end
   function automatic logic signed [31:0] pr(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic signed [63:0] p;
      logic [63:0] m;
      p = 64'(a) * 64'(b);
      m = p[63] ? 64'(-p) : 64'(p);
      m = (m + 64'd536870912) >> 30;
      return p[63] ? -$signed(32'(m)) : $signed(32'(m));
   endfunction
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= n_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= sc_ff[CLAT];
         a1_ff  <= au;
         c1_ff  <= cc;
         sn1_ff <= (cy > ONE_Q30) ? ONE_Q30 : (cy < -ONE_Q30) ? -ONE_Q30 : cy;
         t1_ff  <= ONE_Q30 - cc;
         p1_ff[0] <= pr(au[0], au[0]);
         p1_ff[1] <= pr(au[1], au[1]);
         p1_ff[2] <= pr(au[2], au[2]);
         p1_ff[3] <= pr(au[0], au[1]);
         p1_ff[4] <= pr(au[0], au[2]);
         p1_ff[5] <= pr(au[1], au[2]);
      end
   end

   // stage M2: products with t and sin
   logic               v2_ff;
   side_type           s2_ff;
   logic signed [67:0] ct_ff;
   logic signed [67:0] pt_ff [0:5];
   logic signed [67:0] as_ff [0:2];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s1_ff;
         ct_ff <= 68'(c1_ff) <<< 30;
         for (int k = 0; k < 6; k++) pt_ff[k] <= 68'(p1_ff[k]) * 68'(t1_ff);
         for (int k = 0; k < 3; k++) as_ff[k] <= 68'(a1_ff[k]) * 68'(sn1_ff);
      end
   end

   // stage M3: sums, rounding, output register
   logic [287:0] m_data;
   always_comb begin
      if (s2_ff.zero) begin
         m_data = '0;
         m_data[31:0]    = 32'h40000000;
         m_data[159:128] = 32'h40000000;
         m_data[287:256] = 32'h40000000;
      end else begin
         m_data[31:0]    = rnd_sat(ct_ff + pt_ff[0]);
         m_data[63:32]   = rnd_sat(pt_ff[3] - as_ff[2]);
         m_data[95:64]   = rnd_sat(pt_ff[4] + as_ff[1]);
         m_data[127:96]  = rnd_sat(pt_ff[3] + as_ff[2]);
         m_data[159:128] = rnd_sat(ct_ff + pt_ff[1]);
         m_data[191:160] = rnd_sat(pt_ff[5] - as_ff[0]);
         m_data[223:192] = rnd_sat(pt_ff[4] - as_ff[1]);
         m_data[255:224] = rnd_sat(pt_ff[5] + as_ff[0]);
         m_data[287:256] = rnd_sat(ct_ff + pt_ff[2]);
      end
   end
   assign fin_valid = v2_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (en) rsp_tvalid <= fin_valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata <= m_data;
         rsp_tuser <= s2_ff.zero;
      end
   end

endmodule

### rtl/aarm_cordic.sv
// ----------------------------------------------------------------------------
// aarm_cordic: pipelined CORDIC rotation, one stage per register
// Gives cos and sin in Q2.30 for an angle already reduced to +-pi/2.
// Carries no valid bits; the normaliser's valid chain runs alongside.
// ----------------------------------------------------------------------------
module aarm_cordic import aarm_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] in_z,
   output logic signed [33:0] out_x,
   output logic signed [33:0] out_y
);

   logic signed [33:0]  x_ff [0:CORDIC_STAGES];
   logic signed [33:0]  y_ff [0:CORDIC_STAGES];
   logic signed [33:0]  z_ff [0:CORDIC_STAGES];

   always_comb begin
      x_ff[0] = GAIN_Q30;
      y_ff[0] = '0;
      z_ff[0] = in_z;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [33:0] dx, dy, at;
      assign dx = y_ff[i] >>> (i & 31);
      assign dy = x_ff[i] >>> (i & 31);
      assign at = $signed({2'b00, atan_q30(i)});
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   assign out_x     = x_ff[CORDIC_STAGES];
   assign out_y     = y_ff[CORDIC_STAGES];

endmodule

### rtl/aarm_norm.sv
// ----------------------------------------------------------------------------
// aarm_norm: pipelined axis normaliser
// Magnitude align, sum of squares, digit-per-stage square root, then three
// restoring dividers, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aarm_norm import aarm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [31:0]        in_m [0:2],  // magnitudes, 2^31 allowed as bit 31
   output logic               out_valid,
   output logic [30:0]        out_q [0:2]  // unit magnitudes, Q2.30
);

   // stage 1: align
   logic        v1_ff;
   logic [31:0] m1_ff [0:2];
   logic [31:0] mx;
   logic [4:0]  lz;
   always_comb begin
      mx = in_m[0] | in_m[1] | in_m[2];
      lz = '0;
      for (int b = 0; b < 31; b++) if (mx[b]) lz = 5'(30 - b);
      if (mx[31] || mx[30]) lz = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (en) for (int k = 0; k < 3; k++) m1_ff[k] <= in_m[k] << lz;
   end

   // stage 2: squares
   logic        v2_ff;
   logic [31:0] m2_ff [0:2];
   logic [63:0] sq_ff [0:2];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) for (int k = 0; k < 3; k++) begin
         m2_ff[k] <= m1_ff[k];
         sq_ff[k] <= 64'(m1_ff[k]) * 64'(m1_ff[k]);
      end
   end

   // stage 3: sum, at most 3 * 2^62 so 64 bits hold it
   logic        v3_ff;
   logic [31:0] m3_ff [0:2];
   logic [63:0] s3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         m3_ff <= m2_ff;
         s3_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   // square root: one result bit per stage, remainder form
   logic        sv_ff [0:SQRT_STEPS];
   logic [31:0] sm_ff [0:SQRT_STEPS][0:2];
   logic [63:0] sr_ff [0:SQRT_STEPS]; // radicand shifting out
   logic [34:0] rm_ff [0:SQRT_STEPS]; // partial remainder
   logic [32:0] rt_ff [0:SQRT_STEPS]; // root
   always_comb begin
      sv_ff[0] = v3_ff;
      sm_ff[0] = m3_ff;
      sr_ff[0] = s3_ff;
      rm_ff[0] = '0;
      rt_ff[0] = '0;
   end
   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      logic [34:0] trial, rem;
      assign rem   = {rm_ff[i][32:0], sr_ff[i][63:62]};
      assign trial = {rt_ff[i], 2'b01};
      always_ff @(posedge clock) begin
         if (reset) sv_ff[i+1] <= 1'b0;
         else if (en) sv_ff[i+1] <= sv_ff[i];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sm_ff[i+1] <= sm_ff[i];
            sr_ff[i+1] <= sr_ff[i] << 2;
            if (rem >= trial) begin
               rm_ff[i+1] <= rem - trial;
               rt_ff[i+1] <= {rt_ff[i][31:0], 1'b1};
            end else begin
               rm_ff[i+1] <= rem;
               rt_ff[i+1] <= {rt_ff[i][31:0], 1'b0};
            end
         end
      end
   end

   // divide: q = (m*2^30 + L/2) / L, restoring, one bit per stage
   logic        dv_ff [0:DIV_STEPS];
   logic [32:0] dl_ff [0:DIV_STEPS];
   logic [61:0] dn_ff [0:DIV_STEPS][0:2]; // numerator bits still to feed
   logic [33:0] dr_ff [0:DIV_STEPS][0:2];
   logic [30:0] dq_ff [0:DIV_STEPS][0:2];
   logic [32:0] len;
   assign len = rt_ff[SQRT_STEPS];
   always_comb begin
      dv_ff[0] = sv_ff[SQRT_STEPS];
      dl_ff[0] = len;
      for (int k = 0; k < 3; k++) begin
         logic [62:0] num;
         num = (63'(sm_ff[SQRT_STEPS][k]) << 30) + 63'(len >> 1);
         // quotient <= 2^30 so the top 32 numerator bits stay below L
         dr_ff[0][k] = 34'(num[62:31]);
         dn_ff[0][k] = {num[30:0], 31'd0};
         dq_ff[0][k] = '0;
      end
   end
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) dv_ff[i+1] <= 1'b0;
         else if (en) dv_ff[i+1] <= dv_ff[i];
      end
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [33:0] r;
         assign r = {dr_ff[i][k][32:0], dn_ff[i][k][61]};
         always_ff @(posedge clock) begin
            if (en) begin
               dn_ff[i+1][k] <= dn_ff[i][k] << 1;
               if (r >= 34'(dl_ff[i])) begin
                  dr_ff[i+1][k] <= r - 34'(dl_ff[i]);
                  dq_ff[i+1][k] <= {dq_ff[i][k][29:0], 1'b1};
               end else begin
                  dr_ff[i+1][k] <= r;
                  dq_ff[i+1][k] <= {dq_ff[i][k][29:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) dl_ff[i+1] <= dl_ff[i];
      end
   end

   assign out_valid = dv_ff[DIV_STEPS];
   for (genvar k = 0; k < 3; k++) begin : g_out
      assign out_q[k] = dq_ff[DIV_STEPS][k];
   end

endmodule

### rtl/aarm_checker.sv
// ----------------------------------------------------------------------------
// aarm_checker: port-level checks for the rotation matrix block
// Watches the handshake, reset and the zero-axis result; bound to the top level.
// ----------------------------------------------------------------------------
module aarm_props (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [287:0] rsp_tdata,
   input logic         rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == 32'h40000000
         && rsp_tdata[63:32] == 32'h0)
      else $error("zero axis without identity");

   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("valid after reset");

endmodule

bind axis_angle_rotation_matrix aarm_props u_aarm_props (.*);
